@@ rtl/object_block_deframer_core_assert.svh @@
// assertion macros for the object block deframer
`ifndef OBJECT_BLOCK_DEFRAMER_CORE_ASSERT_SVH
`define OBJECT_BLOCK_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTH
// condition that holds at every clock edge out of reset
`define OBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies another in the next cycle
`define OBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OBD_ASSERT(label, prop, msg)
`define OBD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/obd_pkg.sv @@
package obd_pkg;

    // default width of the stream offset counters
    localparam int OFFSET_BITS_DEF = 24;

    // field widths of the block report
    localparam int OFFSET_OUT_BITS = 24;
    localparam int WORD_BITS       = 16;
    localparam int STATUS_BITS     = 2;

    // header constants
    localparam logic [7:0]           HDR_FIRST  = 8'h01;
    localparam logic [7:0]           HDR_SECOND = 8'h00;
    localparam logic [WORD_BITS-1:0] MIN_LENGTH = 16'd6;

    // parser phase
    typedef enum logic [2:0] {
        PH_H0,
        PH_H1,
        PH_L0,
        PH_L1,
        PH_T0,
        PH_T1,
        PH_BODY,
        PH_HALT
    } phase_t;

    // report status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE   = 2'd0,
        ST_THDR   = 2'd1,
        ST_TBLK   = 2'd2,
        ST_BADLEN = 2'd3
    } status_t;

    // one block report
    typedef struct packed {
        logic [OFFSET_OUT_BITS-1:0] block_offset;
        logic [WORD_BITS-1:0]       block_length;
        logic [WORD_BITS-1:0]       block_kind;
        logic                       checksum_good;
        status_t                    status;
    } report_t;

endpackage

@@ rtl/obd_byte_if.sv @@
interface obd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

@@ rtl/obd_block_if.sv @@
interface obd_block_if;
    logic        valid;
    logic        ready;
    logic [23:0] block_offset;
    logic [15:0] block_length;
    logic [15:0] block_kind;
    logic        checksum_good;
    logic [1:0]  status;

    modport source (
        output valid, output block_offset, output block_length, output block_kind,
        output checksum_good, output status, input ready
    );
    modport sink (
        input valid, input block_offset, input block_length, input block_kind,
        input checksum_good, input status, output ready
    );
endinterface

@@ rtl/object_block_deframer_core.sv @@
// Object block deframer: splits a formatted binary object byte stream into blocks and
// reports offset, length word, type word and checksum status for each block at its
// checksum byte, plus truncated-header, truncated-block and bad-length reports. It takes
// one byte per clock cycle while byte_in.ready is high; a report is registered into the
// output queue when the byte that causes it is accepted. The per-byte work is one 8-bit
// add, a 16-bit counter step and a 16-bit compare against the length word. Reports go
// into a two-entry output queue, so bytes keep flowing while one report waits;
// byte_in.ready drops only while both entries are held. Offsets count from 0 at the
// first byte after reset or after a byte marked end_of_stream, and wrap at OFFSET_BITS
// bits; block_offset gives the low 24 bits.
`include "object_block_deframer_core_assert.svh"

module object_block_deframer_core #(
    parameter int OFFSET_BITS = obd_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    obd_byte_if.sink    byte_in,
    obd_block_if.source block_out
);
    import obd_pkg::*;

    localparam int ExtBits = (OFFSET_BITS > OFFSET_OUT_BITS) ? OFFSET_BITS : OFFSET_OUT_BITS;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [WORD_BITS-1:0]   byte_index_reg, byte_index_next;
    logic [WORD_BITS-1:0]   length_word_reg, length_word_next;
    logic [WORD_BITS-1:0]   type_word_reg, type_word_next;
    logic [7:0]             running_sum_reg, running_sum_next;
    logic [OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [OFFSET_BITS-1:0] stream_offset_reg, stream_offset_next;

    // output queue
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    report_t head_reg, head_next;
    report_t skid_reg, skid_next;

    logic       accept;
    logic       pop;
    logic       push;
    logic [7:0] b;
    logic       eos;
    logic [7:0] sum_plus;
    report_t    rep;
    logic [ExtBits-1:0] start_ext;

    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && byte_in.ready;
    assign pop           = block_out.valid && block_out.ready;
    assign b             = byte_in.data_byte;
    assign eos           = byte_in.end_of_stream;
    assign sum_plus      = running_sum_reg + b;
    assign start_ext     = ExtBits'(start_offset_reg);

    // next parser state
    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        length_word_next   = length_word_reg;
        type_word_next     = type_word_reg;
        running_sum_next   = running_sum_reg;
        start_offset_next  = start_offset_reg;
        stream_offset_next = stream_offset_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_H0:
                begin
                    start_offset_next = stream_offset_reg;
                    running_sum_next  = b;
                    byte_index_next   = WORD_BITS'(1);
                    phase_next        = (b == HDR_FIRST) ? PH_H1 : PH_HALT;
                end
                PH_H1:
                begin
                    running_sum_next = sum_plus;
                    byte_index_next  = WORD_BITS'(2);
                    phase_next       = (b == HDR_SECOND) ? PH_L0 : PH_HALT;
                end
                PH_L0:
                begin
                    running_sum_next = sum_plus;
                    byte_index_next  = byte_index_reg + 1'b1;
                    length_word_next = {8'h00, b};
                    phase_next       = PH_L1;
                end
                PH_L1:
                begin
                    running_sum_next = sum_plus;
                    byte_index_next  = byte_index_reg + 1'b1;
                    length_word_next = {b, length_word_reg[7:0]};
                    phase_next       = PH_T0;
                end
                PH_T0:
                begin
                    running_sum_next = sum_plus;
                    byte_index_next  = byte_index_reg + 1'b1;
                    type_word_next   = {8'h00, b};
                    phase_next       = PH_T1;
                end
                PH_T1:
                begin
                    running_sum_next = sum_plus;
                    byte_index_next  = MIN_LENGTH;
                    type_word_next   = {b, type_word_reg[7:0]};
                    phase_next       = (length_word_reg < MIN_LENGTH) ? PH_HALT : PH_BODY;
                end
                PH_BODY:
                begin
                    if (byte_index_reg == length_word_reg)
                    begin
                        phase_next       = PH_H0;
                        byte_index_next  = '0;
                        running_sum_next = '0;
                    end
                    else
                    begin
                        running_sum_next = sum_plus;
                        byte_index_next  = byte_index_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            stream_offset_next = stream_offset_reg + 1'b1;
            // end of stream starts over
            if (eos)
            begin
                phase_next         = PH_H0;
                byte_index_next    = '0;
                length_word_next   = '0;
                type_word_next     = '0;
                running_sum_next   = '0;
                start_offset_next  = '0;
                stream_offset_next = '0;
            end
        end
    end

    // report for the accepted byte
    always_comb
    begin
        push               = 1'b0;
        rep.block_offset   = start_ext[OFFSET_OUT_BITS-1:0];
        rep.block_length   = '0;
        rep.block_kind     = '0;
        rep.checksum_good  = 1'b0;
        rep.status         = ST_DONE;
        case (phase_reg)
            PH_H1:
            begin
                push       = (b == HDR_SECOND) && eos;
                rep.status = ST_THDR;
            end
            PH_L0, PH_L1, PH_T0:
            begin
                push       = eos;
                rep.status = ST_THDR;
            end
            PH_T1:
            begin
                rep.block_length = length_word_reg;
                rep.block_kind   = {b, type_word_reg[7:0]};
                if (length_word_reg < MIN_LENGTH)
                begin
                    push       = 1'b1;
                    rep.status = ST_BADLEN;
                end
                else
                begin
                    push       = eos;
                    rep.status = ST_TBLK;
                end
            end
            PH_BODY:
            begin
                rep.block_length = length_word_reg;
                rep.block_kind   = type_word_reg;
                if (byte_index_reg == length_word_reg)
                begin
                    push              = 1'b1;
                    rep.checksum_good = (sum_plus == 8'h00);
                    rep.status        = ST_DONE;
                end
                else
                begin
                    push       = eos;
                    rep.status = ST_TBLK;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        push = push && accept;
    end

    // output queue next state
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = push;
                head_next       = rep;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_next       = rep;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = rep;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_H0;
            byte_index_reg    <= '0;
            length_word_reg   <= '0;
            type_word_reg     <= '0;
            running_sum_reg   <= '0;
            start_offset_reg  <= '0;
            stream_offset_reg <= '0;
            head_valid_reg    <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            length_word_reg   <= length_word_next;
            type_word_reg     <= type_word_next;
            running_sum_reg   <= running_sum_next;
            start_offset_reg  <= start_offset_next;
            stream_offset_reg <= stream_offset_next;
            head_valid_reg    <= head_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // report payload registers
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // output beat
    assign block_out.valid         = head_valid_reg;
    assign block_out.block_offset  = head_reg.block_offset;
    assign block_out.block_length  = head_reg.block_length;
    assign block_out.block_kind    = head_reg.block_kind;
    assign block_out.checksum_good = head_reg.checksum_good;
    assign block_out.status        = head_reg.status;

    // checks
    `OBD_ASSERT(a_skid_behind_head, !skid_valid_reg || head_valid_reg, "skid entry without head")
    `OBD_ASSERT_NEXT(a_head_held, head_valid_reg && !pop, head_valid_reg, "waiting report lost")
    `OBD_ASSERT_NEXT(a_eos_restart, accept && eos,
        phase_reg == PH_H0 && stream_offset_reg == '0, "end of stream did not restart")
    `OBD_ASSERT_NEXT(a_halt_sticky, phase_reg == PH_HALT && !(accept && eos),
        phase_reg == PH_HALT, "left halt before end of stream")
    `OBD_ASSERT(a_body_index,
        phase_reg != PH_BODY ||
        (byte_index_reg >= MIN_LENGTH && byte_index_reg <= length_word_reg),
        "body index out of range")

endmodule
